/* hdl/assert_macros.svh */
// Assertion helpers for the ring manager top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define SRDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, also while reset is applied.
`define SRDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/srdm_pkg.sv */
package srdm_pkg;

  localparam int unsigned DEPTH_DEF       = 256;
  localparam int unsigned COOKIE_BITS_DEF = 32;
  localparam int unsigned FIFO_DEPTH      = 2;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_POST = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NODATA  = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;

  typedef enum logic [2:0] {
    K_ENQ  = 3'b001,
    K_DEQ  = 3'b010,
    K_POST = 3'b100
  } kind_e;

  // One classified transaction waiting for the back end.
  typedef struct packed {
    kind_e       kind;
    logic [8:0]  read_count;
    logic [8:0]  write_count;
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic [31:0] cookie;
    logic [7:0]  used_id;
    logic [31:0] used_len;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  desc_index;
    logic [1:0]  desc_flags;
    logic [8:0]  desc_next;
    logic [7:0]  head_index;
    logic [31:0] cookie_out;
    logic [31:0] used_len_out;
    logic [8:0]  in_use;
    logic [15:0] avail_index;
  } result_t;

  // Back end status seen by the front end and the checks.
  typedef struct packed {
    logic        clearing;
    logic [31:0] free_count;
    logic [31:0] ring_n;
  } bstat_t;

endpackage

/* hdl/split_ring_descriptor_manager.sv */
// Split descriptor ring manager, driver side.
// Input channel (in_valid_i/in_ready_o) carries one command per
// transaction: enqueue segment, dequeue completion, or host used post.
// Every known command yields exactly one result transaction on the
// output channel (out_valid_o/out_ready_i); command code 3 is dropped.
// A front end classifies commands into a two-entry queue; a back end
// executes them against the descriptor, link and ring memories.
// A used post, a rejected or dropped segment and a no-data dequeue are
// answered straight from the idle state; a later segment passes through a
// read and a write state; the first segment of a request first reserves
// its descriptors (free list walk through the link memory); a dequeue
// reads the used ring, then walks the completed chain. The back end takes
// its next transaction in the cycle after the result is accepted.
// The result register holds one transaction; while it waits on the
// receiver the back end stalls, and the front end keeps filling its queue.
// Reset, and every write of cfg_wdata_i (ring size), starts a clearing
// pass over all QUEUE_DEPTH entries that rebuilds the free list; no input
// transaction is accepted during it. Write ring size only while idle.
`include "assert_macros.svh"

module split_ring_descriptor_manager import srdm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEF,
  parameter int unsigned COOKIE_BITS = COOKIE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [8:0]  read_count_i,
  input  logic [8:0]  write_count_i,
  input  logic [63:0] seg_addr_i,
  input  logic [31:0] seg_len_i,
  input  logic [31:0] cookie_i,
  input  logic [7:0]  used_id_i,
  input  logic [31:0] used_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  desc_index_o,
  output logic [1:0]  desc_flags_o,
  output logic [8:0]  desc_next_o,
  output logic [7:0]  head_index_o,
  output logic [31:0] cookie_out_o,
  output logic [31:0] used_len_out_o,
  output logic [8:0]  in_use_o,
  output logic [15:0] avail_index_o
);

  bstat_t  bstat;
  logic    q_full, q_push, q_pop, q_valid;
  item_t   q_in, q_out;
  result_t res;

  srdm_front u_front (
    .in_valid_i, .in_ready_o, .cmd_i, .read_count_i,
    .write_count_i, .seg_addr_i, .seg_len_i, .cookie_i, .used_id_i,
    .used_len_i,
    .bstat_i  (bstat),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  srdm_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  srdm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COOKIE_BITS (COOKIE_BITS)
  ) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_ready_i,
    .res_o       (res),
    .bstat_o     (bstat)
  );

  assign status_o       = res.status;
  assign desc_index_o   = res.desc_index;
  assign desc_flags_o   = res.desc_flags;
  assign desc_next_o    = res.desc_next;
  assign head_index_o   = res.head_index;
  assign cookie_out_o   = res.cookie_out;
  assign used_len_out_o = res.used_len_out;
  assign in_use_o       = res.in_use;
  assign avail_index_o  = res.avail_index;

  // The free count never exceeds the ring size.
  `SRDM_ASSERT(a_free_bound, bstat.free_count <= bstat.ring_n, "free count above ring size")
  // The back end only takes from the queue when it holds a transaction.
  `SRDM_ASSERT(a_pop_valid, q_pop |-> q_valid, "pop from empty queue")
  // The queue is never written while full.
  `SRDM_ASSERT(a_push_room, q_push |-> !q_full, "push into full queue")

endmodule

/* hdl/srdm_front.sv */
module srdm_front import srdm_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [8:0]  read_count_i,
  input  logic [8:0]  write_count_i,
  input  logic [63:0] seg_addr_i,
  input  logic [31:0] seg_len_i,
  input  logic [31:0] cookie_i,
  input  logic [7:0]  used_id_i,
  input  logic [31:0] used_len_i,
  input  bstat_t      bstat_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  logic known;

  // Intake pauses while the ring is being rebuilt or the queue is full.
  assign in_ready_o = !q_full_i && !bstat_i.clearing;

  // Classify the command; an unknown code is consumed and dropped.
  always_comb begin
    known            = 1'b1;
    q_item_o.kind    = K_ENQ;
    case (cmd_i)
      CMD_ENQ:  q_item_o.kind = K_ENQ;
      CMD_DEQ:  q_item_o.kind = K_DEQ;
      CMD_POST: q_item_o.kind = K_POST;
      default:  known = 1'b0;
    endcase
    q_item_o.read_count  = read_count_i;
    q_item_o.write_count = write_count_i;
    q_item_o.seg_addr    = seg_addr_i;
    q_item_o.seg_len     = seg_len_i;
    q_item_o.cookie      = cookie_i;
    q_item_o.used_id     = used_id_i;
    q_item_o.used_len    = used_len_i;
  end

  assign q_push_o = in_valid_i && in_ready_o && known;

endmodule

/* hdl/srdm_fifo.sv */
module srdm_fifo import srdm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [FIFO_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(FIFO_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  // Storage for the queued transactions.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* hdl/srdm_back.sv */
module srdm_back import srdm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEF,
  parameter int unsigned COOKIE_BITS = COOKIE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    res_o,
  output bstat_t     bstat_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] LINK_END = LW'(QUEUE_DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_RSV_RD  = 11'b00000000100,
    S_RSV_WT  = 11'b00000001000,
    S_SEG_RD  = 11'b00000010000,
    S_SEG_WT  = 11'b00000100000,
    S_DEQ_U   = 11'b00001000000,
    S_DEQ_C   = 11'b00010000000,
    S_DEQ_K   = 11'b00100000000,
    S_WALK_RD = 11'b01000000000,
    S_WALK_WT = 11'b10000000000
  } state_e;

  // Descriptor table and rings.
  logic [63:0]          addr_mem   [QUEUE_DEPTH];
  logic [31:0]          len_mem    [QUEUE_DEPTH];
  logic [1:0]           flag_mem   [QUEUE_DEPTH];
  logic [LW-1:0]        link_mem   [QUEUE_DEPTH];
  logic [COOKIE_BITS-1:0] cookie_mem [QUEUE_DEPTH];
  logic [7:0]           uid_mem    [QUEUE_DEPTH];
  logic [31:0]          ulen_mem   [QUEUE_DEPTH];

  state_e        state_q, state_d;
  logic [LW-1:0] n_q, n_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [15:0]   avail_q, avail_d, used_q, used_d, last_q, last_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW:0]   free_cnt_q, free_cnt_d;
  logic [IW-1:0] req_head_q, req_head_d;
  logic [LW-1:0] cursor_q, cursor_d;
  logic [9:0]    pos_q, pos_d;
  logic          failed_q, failed_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [9:0]    steps_q, steps_d;
  logic [LW-1:0] count_q, count_d;
  logic [IW-1:0] head_q, head_d;
  logic [31:0]   ulen_q, ulen_d;
  result_t       res_q, res_d;
  logic          ov_q, ov_d;

  logic [IW-1:0]  mask;
  logic [9:0]     total;
  logic [IW-1:0]  link_raddr;
  logic [LW-1:0]  link_rd_q;
  logic [1:0]     flag_rd_q;
  logic [COOKIE_BITS-1:0] cookie_rd_q;
  logic [7:0]     uid_rd_q;
  logic [31:0]    ulen_rd_q;
  logic [IW-1:0]  used_raddr;
  logic           lk_we, fl_we, ad_we, ck_we, ur_we;
  logic [IW-1:0]  lk_waddr, fl_waddr, ad_waddr, ur_waddr;
  logic [LW-1:0]  lk_wdata;
  logic [1:0]     fl_wdata;
  logic [63:0]    ad_wdata;
  logic [31:0]    ln_wdata;
  logic [LW-1:0]  clr_next;
  logic [1:0]     seg_fl;
  logic [LW:0]    fc_sum;
  logic [31:0]    v_eff;
  logic [LW-1:0]  n_cfg;

  assign mask  = IW'(n_q - LW'(1));
  assign total = 10'(q_item_i.read_count) + 10'(q_item_i.write_count);
  assign used_raddr = IW'(last_q) & mask;
  assign clr_next   = LW'(clr_q) + LW'(1);
  assign fc_sum     = free_cnt_q + (LW+1)'(count_q);

  // Ring size from the register value: out of range picks the full depth,
  // otherwise round down to a power of two.
  always_comb begin
    v_eff = 32'(cfg_wdata_i);
    if (v_eff == 32'd0 || v_eff > QUEUE_DEPTH) v_eff = QUEUE_DEPTH;
    n_cfg = LW'(1);
    for (int b = 0; b < 32; b++) begin
      if (v_eff[b]) n_cfg = LW'(32'd1 << b);
    end
  end

  // Flags for the segment at the current position.
  always_comb begin
    seg_fl = 2'b00;
    if (pos_q >= 10'(q_item_i.read_count)) seg_fl[1] = 1'b1;
    if ((pos_q + 10'd1) < total)          seg_fl[0] = 1'b1;
  end

  // Link and flag read address.
  always_comb begin
    case (state_q)
      S_RSV_RD:  link_raddr = IW'(idx_q) & mask;
      S_SEG_RD:  link_raddr = IW'(cursor_q) & mask;
      default:   link_raddr = IW'(idx_q);
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    clr_d       = clr_q;
    avail_d     = avail_q;
    used_d      = used_q;
    last_d      = last_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    req_head_d  = req_head_q;
    cursor_d    = cursor_q;
    pos_d       = pos_q;
    failed_d    = failed_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    count_d     = count_q;
    head_d      = head_q;
    ulen_d      = ulen_q;
    res_d       = res_q;
    ov_d        = ov_q && !out_ready_i;
    q_pop_o     = 1'b0;
    lk_we = 1'b0; lk_waddr = clr_q; lk_wdata = clr_next;
    fl_we = 1'b0; fl_waddr = clr_q; fl_wdata = 2'b00;
    ad_we = 1'b0; ad_waddr = clr_q; ad_wdata = 64'd0; ln_wdata = 32'd0;
    ck_we = 1'b0;
    ur_we = 1'b0; ur_waddr = IW'(used_q) & mask;

    case (state_q)
      S_CLEAR: begin
        // Rebuild the free list one entry a cycle.
        lk_we = 1'b1; fl_we = 1'b1; ad_we = 1'b1;
        lk_wdata = (clr_next < n_q) ? clr_next : LINK_END;
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(QUEUE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i && !ov_q) begin
          res_d = '0;
          res_d.avail_index = avail_q;
          case (q_item_i.kind)
            K_POST: begin
              q_pop_o = 1'b1;
              ur_we   = 1'b1;
              used_d  = used_q + 16'd1;
              res_d.head_index = q_item_i.used_id;
              ov_d = 1'b1;
            end
            K_DEQ: begin
              if (last_q == used_q) begin
                q_pop_o = 1'b1;
                res_d.status = ST_NODATA;
                ov_d = 1'b1;
              end else begin
                state_d = S_DEQ_U;
              end
            end
            K_ENQ: begin
              if (pos_q == 10'd0) begin
                failed_d = 1'b0;
                if (total == 10'd0 || 32'(total) > 32'(n_q) ||
                    32'(total) > 32'(free_cnt_q)) begin
                  q_pop_o = 1'b1;
                  res_d.status = (total == 10'd0 || 32'(total) > 32'(n_q)) ?
                                 ST_INVALID : ST_NOSPACE;
                  if (total > 10'd1) begin
                    failed_d = 1'b1;
                    pos_d    = 10'd1;
                  end
                  ov_d = 1'b1;
                end else begin
                  req_head_d = IW'(free_head_q) & mask;
                  head_d     = IW'(free_head_q) & mask;
                  ck_we      = 1'b1;
                  idx_d      = free_head_q;
                  steps_d    = total;
                  state_d    = S_RSV_RD;
                end
              end else if (failed_q) begin
                q_pop_o = 1'b1;
                res_d.status = ST_DROPPED;
                pos_d = pos_q + 10'd1;
                if ((pos_q + 10'd1) >= total) begin
                  pos_d    = 10'd0;
                  failed_d = 1'b0;
                end
                ov_d = 1'b1;
              end else begin
                state_d = S_SEG_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RSV_RD: begin
        // Reserve descriptors by walking the free list.
        if (steps_q == 10'd0) begin
          free_head_d = idx_q;
          free_cnt_d  = free_cnt_q - (LW+1)'(total);
          cursor_d    = LW'(req_head_q);
          state_d     = S_SEG_RD;
        end else begin
          state_d = S_RSV_WT;
        end
      end
      S_RSV_WT: begin
        idx_d   = link_rd_q;
        steps_d = steps_q - 10'd1;
        state_d = S_RSV_RD;
      end
      S_SEG_RD: state_d = S_SEG_WT;
      S_SEG_WT: begin
        // Fill one descriptor and publish the head after the last one.
        q_pop_o  = 1'b1;
        fl_we    = 1'b1; fl_waddr = IW'(cursor_q) & mask; fl_wdata = seg_fl;
        ad_we    = 1'b1; ad_waddr = IW'(cursor_q) & mask;
        ad_wdata = q_item_i.seg_addr; ln_wdata = q_item_i.seg_len;
        cursor_d = link_rd_q;
        res_d.status     = ST_OK;
        res_d.desc_index = 8'(IW'(cursor_q) & mask);
        res_d.desc_flags = seg_fl;
        res_d.desc_next  = 9'(link_rd_q);
        res_d.head_index = 8'(req_head_q);
        pos_d = pos_q + 10'd1;
        if ((pos_q + 10'd1) >= total) begin
          avail_d = avail_q + 16'd1;
          pos_d   = 10'd0;
        end
        res_d.avail_index = avail_d;
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_DEQ_U: state_d = S_DEQ_C;
      S_DEQ_C: begin
        head_d  = IW'(uid_rd_q) & mask;
        idx_d   = LW'(IW'(uid_rd_q) & mask);
        ulen_d  = ulen_rd_q;
        count_d = LW'(1);
        last_d  = last_q + 16'd1;
        state_d = S_DEQ_K;
      end
      S_DEQ_K: state_d = S_WALK_RD;
      S_WALK_RD: begin
        ad_we = 1'b1; ad_waddr = IW'(idx_q);
        state_d = S_WALK_WT;
      end
      S_WALK_WT: begin
        // Follow NEXT links; at the chain's end, splice the chain onto the front of the free list.
        if (!flag_rd_q[0] || count_q >= n_q) begin
          q_pop_o = 1'b1;
          lk_we = 1'b1; lk_waddr = IW'(idx_q); lk_wdata = free_head_q;
          free_head_d = LW'(head_q);
          free_cnt_d  = (fc_sum > (LW+1)'(n_q)) ? (LW+1)'(n_q) : fc_sum;
          res_d.status       = ST_OK;
          res_d.head_index   = 8'(head_q);
          res_d.cookie_out   = 32'(cookie_rd_q);
          res_d.used_len_out = ulen_q;
          res_d.in_use       = 9'((LW+1)'(n_q) - free_cnt_d);
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = LW'(IW'(link_rd_q) & mask);
          count_d = count_q + LW'(1);
          state_d = S_WALK_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A ring size write restarts the ring state and the clearing pass.
    if (cfg_we_i) begin
      n_d         = n_cfg;
      clr_d       = '0;
      avail_d     = '0;
      used_d      = '0;
      last_d      = '0;
      free_head_d = '0;
      free_cnt_d  = (LW+1)'(n_cfg);
      req_head_d  = '0;
      cursor_d    = '0;
      pos_d       = '0;
      failed_d    = 1'b0;
      state_d     = S_CLEAR;
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    if (fl_we) flag_mem[fl_waddr] <= fl_wdata;
    if (ad_we) begin
      addr_mem[ad_waddr] <= ad_wdata;
      len_mem[ad_waddr]  <= ln_wdata;
    end
    if (ck_we) cookie_mem[IW'(free_head_q) & mask] <= COOKIE_BITS'(q_item_i.cookie);
    if (ur_we) begin
      uid_mem[ur_waddr]  <= q_item_i.used_id;
      ulen_mem[ur_waddr] <= q_item_i.used_len;
    end
    link_rd_q   <= link_mem[link_raddr];
    flag_rd_q   <= flag_mem[link_raddr];
    cookie_rd_q <= cookie_mem[head_q];
    uid_rd_q    <= uid_mem[used_raddr];
    ulen_rd_q   <= ulen_mem[used_raddr];
  end

  // Control and index registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      n_q         <= LW'(QUEUE_DEPTH);
      clr_q       <= '0;
      avail_q     <= '0;
      used_q      <= '0;
      last_q      <= '0;
      free_head_q <= '0;
      free_cnt_q  <= (LW+1)'(QUEUE_DEPTH);
      req_head_q  <= '0;
      cursor_q    <= '0;
      pos_q       <= '0;
      failed_q    <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      clr_q       <= clr_d;
      avail_q     <= avail_d;
      used_q      <= used_d;
      last_q      <= last_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      req_head_q  <= req_head_d;
      cursor_q    <= cursor_d;
      pos_q       <= pos_d;
      failed_q    <= failed_d;
      ov_q        <= ov_d;
    end
  end

  // Work registers and the result register.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    steps_q <= steps_d;
    count_q <= count_d;
    head_q  <= head_d;
    ulen_q  <= ulen_d;
    res_q   <= res_d;
  end

  assign out_valid_o         = ov_q;
  assign res_o               = res_q;
  assign bstat_o.clearing    = (state_q == S_CLEAR);
  assign bstat_o.free_count  = 32'(free_cnt_q);
  assign bstat_o.ring_n      = 32'(n_q);

endmodule

/* bench/tb_split_ring_descriptor_manager.sv */
`timescale 1ns / 100ps

module tb_split_ring_descriptor_manager;
  import srdm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LINK_END = 256;
  localparam int DRAIN_CYCLES = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [8:0]  read_count_i = '0;
  logic [8:0]  write_count_i = '0;
  logic [63:0] seg_addr_i = '0;
  logic [31:0] seg_len_i = '0;
  logic [31:0] cookie_i = '0;
  logic [7:0]  used_id_i = '0;
  logic [31:0] used_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  desc_index_o;
  logic [1:0]  desc_flags_o;
  logic [8:0]  desc_next_o;
  logic [7:0]  head_index_o;
  logic [31:0] cookie_out_o;
  logic [31:0] used_len_out_o;
  logic [8:0]  in_use_o;
  logic [15:0] avail_index_o;

  split_ring_descriptor_manager dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .read_count_i, .write_count_i,
    .seg_addr_i, .seg_len_i, .cookie_i, .used_id_i, .used_len_i,
    .out_valid_o, .out_ready_i, .status_o, .desc_index_o, .desc_flags_o,
    .desc_next_o, .head_index_o, .cookie_out_o, .used_len_out_o,
    .in_use_o, .avail_index_o
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the ring state.
  logic [63:0] sh_addr[256];
  logic [31:0] sh_len[256];
  logic [1:0]  sh_flags[256];
  int          sh_link[256];
  logic [31:0] sh_cookie[256];
  bit          sh_cookie_set[256];
  logic [7:0]  sh_used_id[256];
  logic [31:0] sh_used_len[256];
  logic [15:0] sh_avail_idx, sh_used_idx, sh_last_used;
  int          sh_free_head, sh_free_count, sh_ring_n;
  int          sh_req_head, sh_req_cursor, sh_req_pos;
  bit          sh_req_failed;

  result_t     expected_results[$];
  int          published_heads[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;

  // Rebuild the shadow ring as a write of the ring size does.
  function automatic void ring_rebuild(int value);
    int v;
    int n;
    v = value & 511;
    n = 1;
    if (v == 0 || v > 256) v = 256;
    while (n * 2 <= v) n = n * 2;
    sh_ring_n = n;
    for (int i = 0; i < 256; i++) begin
      sh_addr[i] = '0;
      sh_len[i] = '0;
      sh_flags[i] = '0;
      sh_link[i] = (i + 1 < n) ? i + 1 : LINK_END;
    end
    sh_avail_idx = '0;
    sh_used_idx = '0;
    sh_last_used = '0;
    sh_free_head = 0;
    sh_free_count = n;
    sh_req_head = 0;
    sh_req_cursor = 0;
    sh_req_pos = 0;
    sh_req_failed = 1'b0;
    published_heads.delete();
  endfunction

  // Work out the result of one accepted transaction; returns 0 if none.
  function automatic bit ring_predict(logic [1:0] cmd, int rc, int wc, logic [63:0] addr,
                                      logic [31:0] len, logic [31:0] ck,
                                      logic [7:0] uid, logic [31:0] ulen,
                                      output result_t r);
    int n;
    int total;
    int idx;
    int e;
    int head;
    int count;
    logic [1:0] fl;
    n = sh_ring_n;
    r = '0;
    if (cmd == CMD_ENQ) begin
      total = rc + wc;
      if (sh_req_pos == 0) begin
        sh_req_failed = 1'b0;
        if (total == 0 || total > n || total > sh_free_count) begin
          r.status = (total == 0 || total > n) ? ST_INVALID : ST_NOSPACE;
          if (total > 1) begin
            sh_req_failed = 1'b1;
            sh_req_pos = 1;
          end
          r.avail_index = sh_avail_idx;
          return 1'b1;
        end
        sh_req_head = sh_free_head & (n - 1);
        sh_cookie[sh_req_head] = ck;
        sh_cookie_set[sh_req_head] = 1'b1;
        idx = sh_free_head;
        for (int i = 0; i < total; i++) idx = sh_link[idx & (n - 1)];
        sh_free_head = idx;
        sh_free_count -= total;
        sh_req_cursor = sh_req_head;
      end else if (sh_req_failed) begin
        r.status = ST_DROPPED;
        sh_req_pos++;
        if (sh_req_pos >= total) begin
          sh_req_pos = 0;
          sh_req_failed = 1'b0;
        end
        r.avail_index = sh_avail_idx;
        return 1'b1;
      end
      idx = sh_req_cursor & (n - 1);
      sh_addr[idx] = addr;
      sh_len[idx] = len;
      fl = '0;
      if (sh_req_pos >= rc) fl[1] = 1'b1;
      if (sh_req_pos + 1 < total) fl[0] = 1'b1;
      sh_flags[idx] = fl;
      sh_req_cursor = sh_link[idx];
      r.status = ST_OK;
      r.desc_index = idx[7:0];
      r.desc_flags = fl;
      r.desc_next = sh_link[idx][8:0];
      r.head_index = sh_req_head[7:0];
      sh_req_pos++;
      if (sh_req_pos >= total) begin
        sh_avail_idx = sh_avail_idx + 16'd1;
        sh_req_pos = 0;
        published_heads.push_back(sh_req_head);
      end
      r.avail_index = sh_avail_idx;
      return 1'b1;
    end
    if (cmd == CMD_DEQ) begin
      r.avail_index = sh_avail_idx;
      if (sh_last_used == sh_used_idx) begin
        r.status = ST_NODATA;
        return 1'b1;
      end
      e = sh_last_used & (n - 1);
      sh_last_used = sh_last_used + 16'd1;
      head = sh_used_id[e] & (n - 1);
      r.head_index = head[7:0];
      r.cookie_out = sh_cookie[head];
      r.used_len_out = sh_used_len[e];
      idx = head;
      count = 1;
      forever begin
        sh_addr[idx] = '0;
        sh_len[idx] = '0;
        if (!sh_flags[idx][0] || count >= n) break;
        idx = sh_link[idx] & (n - 1);
        count++;
      end
      sh_link[idx] = sh_free_head;
      sh_free_head = head;
      sh_free_count += count;
      if (sh_free_count > n) sh_free_count = n;
      r.in_use = 9'(n - sh_free_count);
      return 1'b1;
    end
    if (cmd == CMD_POST) begin
      e = sh_used_idx & (n - 1);
      sh_used_id[e] = uid;
      sh_used_len[e] = ulen;
      sh_used_idx = sh_used_idx + 16'd1;
      r.head_index = uid;
      r.avail_index = sh_avail_idx;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one transaction in bursts with random gaps, and predict it on acceptance.
  task automatic send_item(logic [1:0] cmd, int rc, int wc, logic [63:0] addr,
                           logic [31:0] len, logic [31:0] ck,
                           logic [7:0] uid, logic [31:0] ulen);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    read_count_i <= 9'(rc);
    write_count_i <= 9'(wc);
    seg_addr_i <= addr;
    seg_len_i <= len;
    cookie_i <= ck;
    used_id_i <= uid;
    used_len_i <= ulen;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (ring_predict(cmd, rc, wc, addr, len, ck, uid, ulen, r))
      expected_results.push_back(r);
  endtask

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  task automatic enq_seg(int rc, int wc, logic [31:0] ck);
    send_item(CMD_ENQ, rc, wc, rand_addr(), $urandom, ck, 8'($urandom), $urandom);
  endtask

  task automatic host_post(logic [7:0] uid, logic [31:0] ulen);
    send_item(CMD_POST, $urandom_range(0, 256), $urandom_range(0, 256), rand_addr(),
              $urandom, $urandom, uid, ulen);
  endtask

  task automatic dequeue();
    send_item(CMD_DEQ, $urandom_range(0, 256), $urandom_range(0, 256), rand_addr(),
              $urandom, $urandom, 8'($urandom), $urandom);
  endtask

  // A complete well-formed request of rc readable and wc writable segments.
  task automatic full_request(int rc, int wc);
    logic [31:0] ck;
    ck = $urandom;
    for (int i = 0; i < rc + wc; i++) enq_seg(rc, wc, ck);
  endtask

  // Let the ring go quiet: nothing expected and the back end finished.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ring_size(int value);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 9'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ring_rebuild(value);
  endtask

  // Pick a completion id whose head cookie has been written.
  function automatic bit pick_post_id(output logic [7:0] uid);
    int k;
    if (published_heads.size() != 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, published_heads.size() - 1);
      uid = published_heads[k][7:0];
      if (sh_ring_n < 256 && $urandom_range(0, 1) == 1)
        uid = uid | 8'($urandom_range(0, 255) & ~(sh_ring_n - 1));
      published_heads.delete(k);
      return 1'b1;
    end
    for (int t = 0; t < 16; t++) begin
      uid = 8'($urandom_range(0, 255));
      if (sh_cookie_set[uid & (sh_ring_n - 1)]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mixed traffic: mostly well-formed requests, completions and dequeues.
  task automatic run_traffic(int count);
    int stop_at;
    int sel;
    int total;
    int rc;
    int cut;
    logic [7:0] uid;
    logic [31:0] ck;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 48) begin
        if ($urandom_range(0, 19) == 0) total = $urandom_range(1, sh_ring_n);
        else total = $urandom_range(1, (sh_ring_n < 4) ? sh_ring_n : 4);
        rc = $urandom_range(0, total);
        ck = $urandom;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total + 1;
        for (int i = 0; i < total; i++) begin
          if (i == cut) enq_seg(rc, 0, ck);
          else enq_seg(rc, total - rc, ck);
        end
      end else if (sel < 72) begin
        if (pick_post_id(uid)) host_post(uid, $urandom);
      end else if (sel < 96) begin
        dequeue();
      end else if (sel < 98) begin
        send_item(CMD_UNUSED, $urandom_range(0, 256), $urandom_range(0, 256), rand_addr(),
                  $urandom, $urandom, 8'($urandom), $urandom);
      end else begin
        enq_seg($urandom_range(0, 3), $urandom_range(0, 3), $urandom);
      end
    end
  endtask

  // Receiver: long hold-offs on request, otherwise a changing stall pattern.
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) >= 3);
        default: out_ready_i <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, desc_index_o, desc_flags_o, desc_next_o, head_index_o,
              cookie_out_o, used_len_out_o, in_use_o, avail_index_o};
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Field extremes, each status and the odd corners at full ring size.
  task automatic test_directed_corners();
    logic [31:0] ck;
    dequeue();
    enq_seg(0, 0, 32'h0);
    enq_seg(256, 256, 32'h1);
    enq_seg(1, 1, 32'h1);
    send_item(CMD_ENQ, 1, 2, 64'h0, 32'h0, 32'hFFFF_FFFF, 8'hFF, 32'h0);
    send_item(CMD_ENQ, 1, 2, {64{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0, 32'h0);
    send_item(CMD_ENQ, 1, 2, 64'h5555_AAAA_5555_AAAA, 32'h8000_0001, 32'h0, 8'h0, 32'h0);
    host_post(8'd0, 32'hFFFF_FFFF);
    dequeue();
    send_item(CMD_UNUSED, 0, 0, 64'h0, 32'h0, 32'h0, 8'h0, 32'h0);
    ck = 32'h0;
    // Counts shrink on the second segment, which then ends the request.
    enq_seg(1, 3, ck);
    enq_seg(1, 1, ck);
    // A completion for a head that was already returned: corrupt chain.
    host_post(8'd0, 32'h0);
    host_post(8'd0, 32'h1234_5678);
    dequeue();
    dequeue();
    dequeue();
    enq_seg(0, 256, $urandom);
  endtask

  // Small ring: full reservation, no space and a dropped tail.
  task automatic test_small_ring();
    set_ring_size(4);
    full_request(0, 4);
    enq_seg(2, 0, $urandom);
    enq_seg(2, 0, $urandom);
    host_post(8'hFC, 32'h0);
    dequeue();
    full_request(1, 1);
  endtask

  // Each ring size, the extremes and out-of-range writes among them.
  task automatic test_ring_sizes();
    int sizes[14] = '{1, 2, 256, 3, 0, 8, 300, 16, 511, 64, 32, 128, 5, 256};
    foreach (sizes[i]) begin
      set_ring_size(sizes[i]);
      run_traffic(80);
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses.
  task automatic test_backpressure();
    hold_cycles = 400;
    run_traffic(40);
    wait_quiet();
    run_traffic(40);
  endtask

  task automatic test_random_traffic();
    run_traffic(150);
  endtask

  initial begin
    ring_rebuild(256);
    for (int i = 0; i < 256; i++) sh_cookie_set[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_small_ring();
    test_ring_sizes();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    $display("Sent %0d transactions and checked %0d results over 15 ring size settings,",
             items_sent, results_seen);
    $display("with long receiver hold-offs, sender pauses and %0d failures.", errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* split_ring_descriptor_manager.f */
+incdir+hdl
hdl/srdm_pkg.sv
hdl/srdm_front.sv
hdl/srdm_fifo.sv
hdl/srdm_back.sv
hdl/split_ring_descriptor_manager.sv
bench/tb_split_ring_descriptor_manager.sv
